/* sv/srb_pkg.sv */
// Shared types, constants and helper functions of the sample record buffer.
package srb_pkg;

  localparam int BUF_DEPTH   = 4096;
  localparam int SAMPLE_BITS = 24;

  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int LEN_W     = $clog2(BUF_DEPTH + 1);
  localparam int OP_W      = 3;
  localparam int SMP_W     = 24;
  localparam int IDX_W     = 16;
  localparam int POS_W     = 13;
  localparam int CFG_LEN_W = 13;
  localparam int MAX1_W    = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
  localparam int MAX2_W    = (MAX1_W > IDX_W) ? MAX1_W : IDX_W;
  localparam int WIDE_W    = MAX2_W + 1;
  localparam int SX_W      = (SAMPLE_BITS > SMP_W) ? SAMPLE_BITS : SMP_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_BUFFER_LENGTH = 1'b0;
  localparam logic REG_RECORD_MODE   = 1'b1;

  localparam logic [CFG_LEN_W-1:0] BUFFER_LENGTH_RST = CFG_LEN_W'(4096);

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_TICK  = 3'd0;
  localparam op_t OP_START = 3'd1;
  localparam op_t OP_STOP  = 3'd2;
  localparam op_t OP_READ  = 3'd3;
  localparam op_t OP_LOAD  = 3'd4;
  localparam op_t OP_CLEAR = 3'd5;

  typedef struct packed {
    op_t                     op;
    logic signed [SMP_W-1:0] sample;
    logic signed [IDX_W-1:0] index;
    logic                    last;
  } srb_in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] read_sample;
    logic [POS_W-1:0]        record_position;
    logic [POS_W-1:0]        recorded_length;
    logic                    recording;
  } srb_out_t;

  typedef struct packed {
    logic [CFG_LEN_W-1:0] buffer_length;
    logic                 record_mode;
  } srb_cfg_t;

  // Buffer length clamped to 1..BUF_DEPTH.
  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] bl);
    logic [WIDE_W-1:0] b;
    b = WIDE_W'(bl);
    if (b == '0) begin
      b = WIDE_W'(1);
    end else if (b > WIDE_W'(BUF_DEPTH)) begin
      b = WIDE_W'(BUF_DEPTH);
    end
    return b[LEN_W-1:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] to_store(input logic signed [SMP_W-1:0] s);
    logic signed [SX_W-1:0] x;
    x = SX_W'(s);
    return x[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic signed [SMP_W-1:0] from_store(
      input logic signed [SAMPLE_BITS-1:0] w);
    logic signed [SX_W-1:0] x;
    x = SX_W'(w);
    return x[SMP_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] to_pos(input logic [LEN_W-1:0] v);
    logic [WIDE_W-1:0] t;
    t = WIDE_W'(v);
    return t[POS_W-1:0];
  endfunction

endpackage

/* sv/srb_ram.sv */
// Single-port-write, single-port-read sample RAM with registered read data.
module srb_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/srb_cfg.sv */
// APB configuration registers: buffer length and record mode.
module srb_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srb_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [srb_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [srb_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output srb_pkg::srb_cfg_t                 cfg
);

  logic [srb_pkg::CFG_LEN_W-1:0] buffer_length_r;
  logic                          record_mode_r;
  logic                          reg_sel;

  assign reg_sel = paddr[srb_pkg::CFG_ADDR_W-1];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_length_r <= srb_pkg::BUFFER_LENGTH_RST;
      record_mode_r   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        srb_pkg::REG_BUFFER_LENGTH: buffer_length_r <= pwdata[srb_pkg::CFG_LEN_W-1:0];
        srb_pkg::REG_RECORD_MODE:   record_mode_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      srb_pkg::REG_BUFFER_LENGTH: prdata = srb_pkg::CFG_DATA_W'(buffer_length_r);
      srb_pkg::REG_RECORD_MODE:   prdata = srb_pkg::CFG_DATA_W'(record_mode_r);
      default:                    prdata = '0;
    endcase
  end

  assign cfg.buffer_length = buffer_length_r;
  assign cfg.record_mode   = record_mode_r;

endmodule

/* sv/srb_ctrl.sv */
// Request sequencer: decodes operations, drives the sample RAM and holds the result.
module srb_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  srb_pkg::srb_cfg_t                  cfg,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  srb_pkg::srb_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output srb_pkg::srb_out_t                  out_data,
  output logic                               ram_we,
  output logic [srb_pkg::ADDR_W-1:0]         ram_waddr,
  output logic [srb_pkg::SAMPLE_BITS-1:0]    ram_wdata,
  output logic                               ram_re,
  output logic [srb_pkg::ADDR_W-1:0]         ram_raddr,
  input  logic [srb_pkg::SAMPLE_BITS-1:0]    ram_rdata
);

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_READ, S_ZERO, S_HOLD} state_t;

  state_t                       state_r, state_nxt;
  logic [srb_pkg::LEN_W-1:0]    zaddr_r, zaddr_nxt, zaddr_inc;
  logic [srb_pkg::LEN_W-1:0]    wp_r, wp_nxt, wp_clip, wp_adv;
  logic [srb_pkg::LEN_W-1:0]    take_r, take_nxt;
  logic                         active_r, active_nxt;
  logic                         rd_ok_r, rd_ok_nxt;
  logic                         out_valid_r;
  srb_pkg::srb_out_t            out_data_r, res_r, fin_res;

  logic [srb_pkg::LEN_W-1:0]    len;
  logic [srb_pkg::WIDE_W-1:0]   len_w, idx_w, nl_w;
  logic [srb_pkg::LEN_W-1:0]    nl;
  logic                         idx_neg, in_rng, wp_room;
  logic                         acc, zero_go, finish, out_free, load_out, zlast;

  function automatic srb_pkg::srb_out_t make_res(
      input logic signed [srb_pkg::SMP_W-1:0] rd,
      input logic [srb_pkg::LEN_W-1:0]        wp,
      input logic [srb_pkg::LEN_W-1:0]        tl,
      input logic                             act);
    srb_pkg::srb_out_t r;
    r.read_sample     = rd;
    r.record_position = srb_pkg::to_pos(wp);
    r.recorded_length = srb_pkg::to_pos(tl);
    r.recording       = act;
    return r;
  endfunction

  assign len      = srb_pkg::eff_len(cfg.buffer_length);
  assign len_w    = srb_pkg::WIDE_W'(len);
  assign idx_neg  = in_data.index[srb_pkg::IDX_W-1];
  assign idx_w    = srb_pkg::WIDE_W'(in_data.index[srb_pkg::IDX_W-1:0]);
  assign in_rng   = !idx_neg && (idx_w < len_w);
  assign nl_w     = idx_w + srb_pkg::WIDE_W'(1);
  assign nl       = idx_neg ? '0 : ((nl_w > len_w) ? len : nl_w[srb_pkg::LEN_W-1:0]);

  assign wp_clip  = (wp_r > len) ? len : wp_r;
  assign wp_room  = wp_clip < len;
  assign wp_adv   = wp_room ? srb_pkg::LEN_W'(wp_clip + 1'b1) : wp_clip;
  assign zaddr_inc = srb_pkg::LEN_W'(zaddr_r + 1'b1);
  assign zlast    = zaddr_inc >= len;

  assign acc      = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Operation decode and RAM port control
  always_comb begin
    wp_nxt     = wp_r;
    active_nxt = active_r;
    take_nxt   = take_r;
    rd_ok_nxt  = rd_ok_r;
    zero_go    = 1'b0;
    zaddr_nxt  = zaddr_r;
    ram_we     = 1'b0;
    ram_waddr  = zaddr_r[srb_pkg::ADDR_W-1:0];
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = idx_w[srb_pkg::ADDR_W-1:0];
    if (state_r == S_INIT || state_r == S_ZERO) begin
      ram_we    = 1'b1;
      zaddr_nxt = zaddr_inc;
    end else if (acc) begin
      unique case (in_data.op)
        srb_pkg::OP_TICK: begin
          if (active_r) begin
            ram_we    = wp_room;
            ram_waddr = wp_clip[srb_pkg::ADDR_W-1:0];
            ram_wdata = srb_pkg::to_store(in_data.sample);
            wp_nxt    = wp_adv;
            if (wp_adv >= len) begin
              if (cfg.record_mode) begin
                wp_nxt = '0;
              end else begin
                active_nxt = 1'b0;
                take_nxt   = wp_adv;
              end
            end
          end
        end
        srb_pkg::OP_START: begin
          active_nxt = 1'b1;
          wp_nxt     = '0;
        end
        srb_pkg::OP_STOP: begin
          active_nxt = 1'b0;
          take_nxt   = wp_r;
        end
        srb_pkg::OP_READ: begin
          ram_re    = in_rng;
          rd_ok_nxt = in_rng;
        end
        srb_pkg::OP_LOAD: begin
          ram_we    = in_rng;
          ram_waddr = idx_w[srb_pkg::ADDR_W-1:0];
          ram_wdata = srb_pkg::to_store(in_data.sample);
          if (in_data.last) begin
            take_nxt  = nl;
            zero_go   = nl < len;
            zaddr_nxt = nl;
          end
        end
        srb_pkg::OP_CLEAR: begin
          zero_go   = 1'b1;
          zaddr_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // Completion and next state
  always_comb begin
    finish    = 1'b0;
    fin_res   = make_res('0, wp_r, take_r, active_r);
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (zaddr_r == srb_pkg::LEN_W'(srb_pkg::BUF_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.op == srb_pkg::OP_READ) begin
            state_nxt = S_READ;
          end else if (zero_go) begin
            state_nxt = S_ZERO;
          end else begin
            finish  = 1'b1;
            fin_res = make_res('0, wp_nxt, take_nxt, active_nxt);
          end
        end
      end
      S_READ: begin
        finish  = 1'b1;
        fin_res = make_res(rd_ok_r ? srb_pkg::from_store(ram_rdata) : '0,
                           wp_r, take_r, active_r);
      end
      S_ZERO: begin
        finish = zlast;
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (finish) begin
      state_nxt = out_free ? S_IDLE : S_HOLD;
    end
  end

  assign load_out = (finish || state_r == S_HOLD) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      zaddr_r     <= '0;
      wp_r        <= '0;
      take_r      <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      zaddr_r  <= zaddr_nxt;
      wp_r     <= wp_nxt;
      take_r   <= take_nxt;
      active_r <= active_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_data_r  <= (state_r == S_HOLD) ? res_r : fin_res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (finish && !out_free) begin
        res_r <= fin_res;
      end
    end
    rd_ok_r <= rd_ok_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/sample_record_buffer.sv */
// Top level of the sample record buffer: config registers, sequencer and sample RAM.
//
//  channel  | ports                                   | moves
//  ---------+-----------------------------------------+-------------------------------
//  in       | in_valid, in_stall, in_data             | one operation request
//  out      | out_valid, out_stall, out_data          | one result per request
//  cfg      | cfg_psel..cfg_pready (APB)              | buffer_length, record_mode
//
// Tick, start, stop, load without zero fill and unused codes: the result is registered from the
// accepted request. Read: the request waits in S_READ for the registered RAM read port.
// Clear and load marked last zero from 0 or the new length in S_ZERO, one RAM write a cycle.
// After reset the whole RAM is zeroed in S_INIT with in_stall high.
// A stalled result is held while the next request is taken and executed.
module sample_record_buffer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  srb_pkg::srb_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output srb_pkg::srb_out_t                out_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [srb_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [srb_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [srb_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  srb_pkg::srb_cfg_t                cfg;
  logic                             ram_we, ram_re;
  logic [srb_pkg::ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [srb_pkg::SAMPLE_BITS-1:0]  ram_wdata, ram_rdata;

  srb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  srb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  srb_ram #(
    .DEPTH (srb_pkg::BUF_DEPTH),
    .WIDTH (srb_pkg::SAMPLE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* sv/srb_checker.sv */
// Port-level checks of the sample record buffer, bound to the top level.
module srb_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input srb_pkg::srb_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input srb_pkg::srb_out_t out_data
);

  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request taken during RAM zeroing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.op == srb_pkg::OP_READ |=> in_stall)
    else $error("read did not wait for RAM data");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.record_position <= srb_pkg::BUF_DEPTH &&
                  out_data.recorded_length <= srb_pkg::BUF_DEPTH)
    else $error("pointer beyond buffer depth");

endmodule

bind sample_record_buffer srb_checker u_srb_checker (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench for the sample record buffer: directed and random requests.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import srb_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_BUFFER_LENGTH = CFG_ADDR_W'(4 * REG_BUFFER_LENGTH);
  localparam logic [CFG_ADDR_W-1:0] ADDR_RECORD_MODE   = CFG_ADDR_W'(4 * REG_RECORD_MODE);
  localparam int LONG_HOLD = 200;
  localparam int HEAVY_LEN = 64;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  srb_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  srb_out_t              out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // predictor state and its copy of the registers
  logic signed [SMP_W-1:0] sample_mem [BUF_DEPTH];
  int                      rec_ptr;
  bit                      rec_on;
  int                      take_len;
  logic [CFG_LEN_W-1:0]    buf_len_reg;
  bit                      loop_mode;

  srb_in_t  pending_requests [$];
  srb_out_t expected_results [$];
  int       mismatch_count = 0;
  int       src_gap = 0;
  int       sink_gap = 0;
  int       hold_left = 0;
  int       hold_asked = 0;
  int       hold_done = 0;
  bit       no_idle = 1'b0;

  sample_record_buffer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int active_len();
    if (buf_len_reg == '0) begin
      return 1;
    end
    if (int'(buf_len_reg) > BUF_DEPTH) begin
      return BUF_DEPTH;
    end
    return int'(buf_len_reg);
  endfunction

  function automatic srb_out_t predict_result(srb_in_t req);
    srb_out_t res;
    int len;
    int idx;
    int nl;
    int i;
    len = active_len();
    idx = int'($signed(req.index));
    res = '0;
    case (req.op)
      OP_TICK: begin
        if (rec_on) begin
          if (rec_ptr > len) rec_ptr = len;
          if (rec_ptr < len) begin
            sample_mem[rec_ptr] = req.sample;
            rec_ptr++;
          end
          if (rec_ptr >= len) begin
            if (!loop_mode) begin
              rec_on = 1'b0;
              take_len = rec_ptr;
            end else begin
              rec_ptr = 0;
            end
          end
        end
      end
      OP_START: begin
        rec_on = 1'b1;
        rec_ptr = 0;
      end
      OP_STOP: begin
        rec_on = 1'b0;
        take_len = rec_ptr;
      end
      OP_READ: begin
        if (idx >= 0 && idx < len) res.read_sample = sample_mem[idx];
      end
      OP_LOAD: begin
        if (idx >= 0 && idx < len) sample_mem[idx] = req.sample;
        if (req.last) begin
          nl = idx + 1;
          if (nl < 0) nl = 0;
          if (nl > len) nl = len;
          for (i = nl; i < len; i++) sample_mem[i] = '0;
          take_len = nl;
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < len; i++) sample_mem[i] = '0;
      end
      default: begin
      end
    endcase
    res.record_position = POS_W'(rec_ptr);
    res.recorded_length = POS_W'(take_len);
    res.recording = rec_on;
    return res;
  endfunction

  task automatic check_result(input srb_out_t got);
    srb_out_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with none expected: %h", $time, got);
      mismatch_count++;
      return;
    end
    want = expected_results.pop_front();
    if (got.read_sample !== want.read_sample) begin
      $display("%0t: read_sample expected %h, got %h", $time, want.read_sample,
               got.read_sample);
      mismatch_count++;
    end
    if (got.record_position !== want.record_position) begin
      $display("%0t: record_position expected %0d, got %0d", $time, want.record_position,
               got.record_position);
      mismatch_count++;
    end
    if (got.recorded_length !== want.recorded_length) begin
      $display("%0t: recorded_length expected %0d, got %0d", $time, want.recorded_length,
               got.recorded_length);
      mismatch_count++;
    end
    if (got.recording !== want.recording) begin
      $display("%0t: recording expected %b, got %b", $time, want.recording, got.recording);
      mismatch_count++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_result(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_data <= pending_requests.pop_front();
          in_valid <= 1'b1;
          if (!no_idle && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_done != hold_asked) begin
        hold_done++;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    case (addr)
      ADDR_BUFFER_LENGTH: buf_len_reg = CFG_LEN_W'(value);
      ADDR_RECORD_MODE:   loop_mode = value[0];
      default: begin
      end
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_request(input op_t op, input logic [SMP_W-1:0] smp, input int idx,
                               input logic lst);
    srb_in_t req;
    req.op = op;
    req.sample = smp;
    req.index = IDX_W'(idx);
    req.last = lst;
    pending_requests.push_back(req);
  endtask

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7F_FFFF;
      1: return 24'h80_0000;
      2: return '0;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // mostly well-formed takes and load runs, with noise mixed in
  task automatic queue_phase_traffic(input int count);
    int len;
    int first;
    int kind;
    int k;
    int n;
    int base;
    int i;
    bit heavy;
    srb_in_t req;
    len = active_len();
    heavy = len > HEAVY_LEN;
    first = pending_requests.size();
    if (heavy) queue_request(OP_CLEAR, rand_sample(), 0, 1'b0);
    while (pending_requests.size() - first < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        queue_request(OP_START, rand_sample(), $urandom_range(0, 65535),
                      1'($urandom_range(0, 1)));
        k = $urandom_range(1, heavy ? 20 : len + 3);
        repeat (k) queue_request(OP_TICK, rand_sample(), $urandom_range(0, 65535), 1'b0);
        if ($urandom_range(0, 1)) queue_request(OP_STOP, rand_sample(), 0, 1'b0);
      end else if (kind < 50) begin
        n = $urandom_range(1, (len < 12) ? len : 12);
        base = heavy ? len - n : $urandom_range(0, len - n);
        for (i = 0; i < n; i++) begin
          queue_request(OP_LOAD, rand_sample(), base + i,
                        (i == n - 1) && ($urandom_range(0, 9) != 0));
        end
        if ($urandom_range(0, 1)) begin
          for (i = 0; i < n; i++) queue_request(OP_READ, '0, base + i, 1'b0);
        end
      end else if (kind < 70) begin
        k = $urandom_range(1, 6);
        repeat (k) queue_request(OP_READ, rand_sample(), $urandom_range(0, len + 1),
                                 1'($urandom_range(0, 1)));
      end else begin
        req.op = op_t'($urandom_range(0, 7));
        req.sample = rand_sample();
        req.index = ($urandom_range(0, 1) != 0) ? IDX_W'($urandom) :
                    IDX_W'(int'($urandom_range(0, len + 4)) - 2);
        req.last = 1'($urandom_range(0, 1));
        if (heavy && req.op == OP_CLEAR && $urandom_range(0, 9) != 0) req.op = OP_READ;
        if (heavy && req.op == OP_LOAD && req.last && $signed(req.index) < len - 16) begin
          req.index = IDX_W'(len - 1 - int'($urandom_range(0, 15)));
        end
        pending_requests.push_back(req);
      end
    end
  endtask

  int phase_len [12] = '{1, 0, 2, 16, 4096, 33, 64, 8191, 5, 12, 5000, 3};

  initial begin
    int i;
    int m;
    int p;
    for (i = 0; i < BUF_DEPTH; i++) sample_mem[i] = '0;
    rec_ptr = 0;
    rec_on = 1'b0;
    take_len = 0;
    buf_len_reg = CFG_LEN_W'(4096);
    loop_mode = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    while (in_stall) @(negedge clk);

    write_reg(ADDR_BUFFER_LENGTH, 8);
    write_reg(ADDR_RECORD_MODE, 0);
    queue_request(OP_READ, '0, 0, 1'b0);
    queue_request(OP_TICK, 24'h7F_FFFF, 0, 1'b0);
    queue_request(OP_STOP, '0, 0, 1'b0);
    queue_request(OP_START, '0, 0, 1'b0);
    queue_request(OP_TICK, 24'h7F_FFFF, 0, 1'b0);
    queue_request(OP_TICK, 24'h80_0000, 0, 1'b0);
    queue_request(OP_TICK, 24'hFF_FFFF, 0, 1'b0);
    queue_request(OP_START, '0, 0, 1'b0);
    queue_request(OP_TICK, 24'h12_3456, 0, 1'b0);
    queue_request(OP_STOP, '0, 0, 1'b0);
    queue_request(OP_READ, '0, 0, 1'b0);
    queue_request(OP_READ, '0, -1, 1'b0);
    queue_request(OP_READ, '0, 8, 1'b0);
    queue_request(OP_READ, '0, -32768, 1'b1);
    queue_request(OP_READ, '0, 32767, 1'b0);
    queue_request(OP_LOAD, 24'h80_0000, 7, 1'b0);
    queue_request(OP_LOAD, 24'h7F_FFFF, 32767, 1'b1);
    queue_request(OP_LOAD, 24'h55_AAAA, -32768, 1'b1);
    queue_request(OP_LOAD, 24'hAA_5555, 3, 1'b0);
    queue_request(OP_LOAD, 24'h7F_FFFF, 5, 1'b1);
    queue_request(OP_READ, '0, 3, 1'b0);
    queue_request(OP_CLEAR, '0, 0, 1'b0);
    queue_request(OP_READ, '0, 3, 1'b0);
    queue_request(op_t'(6), 24'hFF_FFFF, -1, 1'b1);
    queue_request(op_t'(7), '0, 0, 1'b0);
    wait_idle();

    // pointer left beyond a shrunk length, in loop and then one-shot mode
    for (m = 1; m >= 0; m--) begin
      write_reg(ADDR_BUFFER_LENGTH, 40);
      write_reg(ADDR_RECORD_MODE, m);
      queue_request(OP_START, '0, 0, 1'b0);
      repeat (30) queue_request(OP_TICK, rand_sample(), 0, 1'b0);
      wait_idle();
      write_reg(ADDR_BUFFER_LENGTH, 8);
      queue_request(OP_TICK, rand_sample(), 0, 1'b0);
      queue_request(OP_TICK, rand_sample(), 0, 1'b0);
      queue_request(OP_READ, '0, 0, 1'b0);
      wait_idle();
    end

    for (p = 0; p < 24; p++) begin
      write_reg(ADDR_BUFFER_LENGTH, phase_len[p % 12]);
      write_reg(ADDR_RECORD_MODE, (p + p / 12) % 2);
      if (p >= 21) no_idle = 1'b1;
      if (p == 6) hold_asked++;
      queue_phase_traffic((active_len() > HEAVY_LEN) ? 50 : 70);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
